// ----- rtl/pcst_pkg.sv -----
// Package for the peer credit score tracker: opcodes, identity codes, constants, state type.
// No dependencies.
package pcst_pkg;

    localparam int unsigned MAX_KEY_BYTES = 80;

    localparam logic [2:0] OP_ADD_DOWN  = 3'd0;
    localparam logic [2:0] OP_ADD_UP    = 3'd1;
    localparam logic [2:0] OP_QUERY     = 3'd2;
    localparam logic [2:0] OP_KEY       = 3'd3;
    localparam logic [2:0] OP_VERIFY    = 3'd4;
    localparam logic [2:0] OP_FAIL      = 3'd5;

    localparam logic [1:0] ID_NONE      = 2'd0;
    localparam logic [1:0] ID_NEEDED    = 2'd1;
    localparam logic [1:0] ID_DONE      = 2'd2;
    localparam logic [1:0] ID_FAILED    = 2'd3;
    localparam logic [2:0] EFF_ELSEWHERE = 3'd4;

    localparam logic [15:0] ONE_Q12 = 16'd4096;
    localparam logic [15:0] TEN_Q12 = 16'd40960;
    localparam logic [63:0] MIB      = 64'd1048576;
    localparam logic [63:0] RAMP_END = 64'd9646899;
    localparam logic [63:0] ROOT_END = 64'd102760448;
    // 100 * 8598323
    localparam logic [63:0] RAMP_DIV = 64'd859832300;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_DIV,
        ST_ROOT,
        ST_RAMP,
        ST_DONE
    } state_t;

endpackage

// ----- rtl/peer_credit_score_tracker.sv -----
// Top level of the peer credit score tracker.
// Depends on pcst_pkg.
//
// One peer's credit record. Adds, key offers, verifications and unused opcodes,
// and queries below 1 MiB or gated, have their result registered when accepted.
// A score query from 1 MiB on runs a shared one-bit-per-cycle restoring divider
// and a two-bit-per-cycle square root: the ratio division gives 64 quotient
// bits plus 13 fraction bits, the root 32 bits and the ramp division 64 bits.
// The ratio division is skipped when its term saturates, and from 98 MiB on
// the root and ramp are skipped as well.
// One item is worked at a time; the output register
// holds a result until its transfer and the next item is then taken.
module peer_credit_score_tracker (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_we,
    input  logic        cfg_wdata,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [2:0]  opcode,
    input  logic [31:0] byte_count,
    input  logic [31:0] peer_address,
    input  logic [7:0]  key_length,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [15:0] score_ratio,
    output logic        accepted,
    output logic [2:0]  effective_ident
);

    logic        crypto_reg;
    logic [63:0] down_reg, up_reg;
    logic [1:0]  ident_reg;
    logic [31:0] addr_reg;
    logic [6:0]  offer_reg, stored_reg;

    pcst_pkg::state_t state_reg, state_next;
    logic [6:0]  cnt_reg, cnt_next;
    // shared divider / root working registers
    logic [63:0] num_reg, num_next;   // dividend shifted out msb first
    logic [64:0] rem_reg, rem_next;
    logic [63:0] den_reg, den_next;
    logic [63:0] quo_reg, quo_next;
    logic [15:0] best_reg, best_next;
    logic [31:0] qaddr_reg;
    logic [15:0] score_reg, score_next;
    logic        ovalid_reg, ovalid_next;
    logic        acc_reg;

    logic [2:0] eff_in;
    logic       gated_in;
    logic       take;

    // ramp numerator (D - 1 MiB) * 234 * 4096; only used below the ramp end,
    // where D - 1 MiB fits in 24 bits
    logic [23:0] ramp_off;
    logic [31:0] ramp_prod;
    logic [63:0] ramp_num;
    // 5 * U for the saturated-ratio test
    logic [66:0] up_x5;

    function automatic logic [2:0] eff_of(input logic [1:0] st, input logic [31:0] a,
                                          input logic [31:0] ia);
        if (st != pcst_pkg::ID_DONE)
            return {1'b0, st};
        return (a == ia) ? {1'b0, pcst_pkg::ID_DONE} : pcst_pkg::EFF_ELSEWHERE;
    endfunction

    assign eff_in   = eff_of(ident_reg, peer_address, addr_reg);
    assign gated_in = crypto_reg && (eff_in != {1'b0, pcst_pkg::ID_NONE})
                      && (eff_in != {1'b0, pcst_pkg::ID_DONE});
    assign in_ready = (state_reg == pcst_pkg::ST_IDLE) && !ovalid_reg;
    assign take     = in_valid && in_ready;

    assign ramp_off  = down_reg[23:0] - 24'(pcst_pkg::MIB);
    assign ramp_prod = {8'd0, ramp_off} * 32'd234;
    assign ramp_num  = {20'd0, ramp_prod, 12'd0};
    assign up_x5     = {1'b0, up_reg, 2'b00} + {3'b000, up_reg};

    assign out_valid       = ovalid_reg;
    assign score_ratio     = score_reg;
    assign accepted        = acc_reg;
    // record state holds still while a result waits, so this is the state after the step
    assign effective_ident = eff_of(ident_reg, qaddr_reg, addr_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            crypto_reg <= 1'b0;
        else if (cfg_we)
            crypto_reg <= cfg_wdata;
    end

    // record state, updated when an item is taken
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            down_reg   <= '0;
            up_reg     <= '0;
            ident_reg  <= pcst_pkg::ID_NONE;
            addr_reg   <= '0;
            offer_reg  <= '0;
            stored_reg <= '0;
        end
        else if (take)
        begin
            case (opcode)
                pcst_pkg::OP_ADD_DOWN:
                    if (!gated_in) down_reg <= down_reg + {32'd0, byte_count};
                pcst_pkg::OP_ADD_UP:
                    if (!gated_in) up_reg <= up_reg + {32'd0, byte_count};
                pcst_pkg::OP_KEY:
                    if (key_length <= 8'(pcst_pkg::MAX_KEY_BYTES) && stored_reg == '0)
                    begin
                        offer_reg <= key_length[6:0];
                        ident_reg <= pcst_pkg::ID_NEEDED;
                    end
                pcst_pkg::OP_VERIFY:
                begin
                    addr_reg  <= peer_address;
                    ident_reg <= pcst_pkg::ID_DONE;
                    if (stored_reg == '0)
                    begin
                        stored_reg <= offer_reg;
                        if (down_reg != '0)
                        begin
                            down_reg <= 64'd1;
                            up_reg   <= 64'd1;
                        end
                    end
                end
                pcst_pkg::OP_FAIL:
                    ident_reg <= pcst_pkg::ID_FAILED;
                default: ;
            endcase
        end
    end

    // accepted is known at take; hold the item address for the effective identity
    always_ff @(posedge clk)
    begin
        if (take)
        begin
            qaddr_reg <= peer_address;
            case (opcode)
                pcst_pkg::OP_ADD_DOWN, pcst_pkg::OP_ADD_UP: acc_reg <= !gated_in;
                pcst_pkg::OP_KEY:
                    acc_reg <= (key_length <= 8'(pcst_pkg::MAX_KEY_BYTES))
                               && (stored_reg == '0);
                default: acc_reg <= 1'b0;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= pcst_pkg::ST_IDLE;
            ovalid_reg <= 1'b0;
            cnt_reg    <= '0;
        end
        else
        begin
            state_reg  <= state_next;
            ovalid_reg <= ovalid_next;
            cnt_reg    <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        num_reg   <= num_next;
        rem_reg   <= rem_next;
        den_reg   <= den_next;
        quo_reg   <= quo_next;
        best_reg  <= best_next;
        score_reg <= score_next;
    end

    logic [64:0] trial;
    logic [65:0] rtrial;
    logic [65:0] rrem;

    always_comb
    begin
        state_next  = state_reg;
        cnt_next    = cnt_reg;
        num_next    = num_reg;
        rem_next    = rem_reg;
        den_next    = den_reg;
        quo_next    = quo_reg;
        best_next   = best_reg;
        score_next  = score_reg;
        ovalid_next = ovalid_reg;
        trial       = {rem_reg[63:0], num_reg[63]} - {1'b0, den_reg};
        rrem        = {rem_reg[63:0], num_reg[63:62]};
        rtrial      = rrem - {quo_reg[63:0], 2'b01};

        if (ovalid_reg && out_ready)
            ovalid_next = 1'b0;

        case (state_reg)
            pcst_pkg::ST_IDLE:
                if (take)
                begin
                    score_next = pcst_pkg::ONE_Q12;
                    if (opcode == pcst_pkg::OP_QUERY && !gated_in
                        && down_reg >= pcst_pkg::MIB)
                    begin
                        best_next = pcst_pkg::TEN_Q12;
                        if (up_reg == '0 || up_x5 <= {3'b000, down_reg})
                        begin
                            state_next = pcst_pkg::ST_ROOT;
                            num_next   = (down_reg << 4) + (64'd1 << 25);
                            rem_next   = '0;
                            quo_next   = '0;
                            cnt_next   = 7'd32;
                            // root and ramp both saturate here
                            if (down_reg >= pcst_pkg::ROOT_END)
                                state_next = pcst_pkg::ST_DONE;
                        end
                        else
                        begin
                            state_next = pcst_pkg::ST_DIV;
                            num_next   = down_reg;
                            den_next   = up_reg;
                            rem_next   = '0;
                            quo_next   = '0;
                            cnt_next   = 7'd77;
                        end
                    end
                    else
                        ovalid_next = 1'b1;
                end
            pcst_pkg::ST_DIV, pcst_pkg::ST_RAMP:
            begin
                // restoring division, one quotient bit per cycle
                if (!trial[64])
                begin
                    rem_next = {1'b0, trial[63:0]};
                    quo_next = {quo_reg[62:0], 1'b1};
                end
                else
                begin
                    rem_next = {rem_reg[63:0], num_reg[63]};
                    quo_next = {quo_reg[62:0], 1'b0};
                end
                num_next = {num_reg[62:0], 1'b0};
                cnt_next = cnt_reg - 7'd1;
                if (cnt_reg == 7'd1)
                begin
                    if (state_reg == pcst_pkg::ST_DIV)
                    begin
                        if (quo_next < 64'(pcst_pkg::TEN_Q12))
                            best_next = quo_next[15:0];
                        state_next = pcst_pkg::ST_ROOT;
                        num_next   = (down_reg << 4) + (64'd1 << 25);
                        rem_next   = '0;
                        quo_next   = '0;
                        cnt_next   = 7'd32;
                        if (down_reg >= pcst_pkg::ROOT_END)
                            state_next = pcst_pkg::ST_DONE;
                    end
                    else
                    begin
                        if ((quo_next + 64'(pcst_pkg::ONE_Q12)) < 64'(best_reg))
                            best_next = quo_next[15:0] + pcst_pkg::ONE_Q12;
                        state_next = pcst_pkg::ST_DONE;
                    end
                end
            end
            pcst_pkg::ST_ROOT:
            begin
                // digit-by-digit root, two radicand bits per cycle
                if (!rtrial[65])
                begin
                    rem_next = rtrial[64:0];
                    quo_next = {quo_reg[62:0], 1'b1};
                end
                else
                begin
                    rem_next = rrem[64:0];
                    quo_next = {quo_reg[62:0], 1'b0};
                end
                num_next = {num_reg[61:0], 2'b00};
                cnt_next = cnt_reg - 7'd1;
                if (cnt_reg == 7'd1)
                begin
                    if (quo_next < 64'(best_reg))
                        best_next = quo_next[15:0];
                    if (down_reg >= pcst_pkg::RAMP_END)
                        state_next = pcst_pkg::ST_DONE;
                    else
                    begin
                        state_next = pcst_pkg::ST_RAMP;
                        cnt_next   = 7'd64;
                        num_next   = ramp_num;
                        den_next   = pcst_pkg::RAMP_DIV;
                        rem_next   = '0;
                        quo_next   = '0;
                    end
                end
            end
            pcst_pkg::ST_DONE:
            begin
                score_next  = (best_reg < pcst_pkg::ONE_Q12) ? pcst_pkg::ONE_Q12 : best_reg;
                ovalid_next = 1'b1;
                state_next  = pcst_pkg::ST_IDLE;
            end
            default: state_next = pcst_pkg::ST_IDLE;
        endcase
    end

endmodule
